[hdl/touch_event_tracker_core_assert.svh]
// Assertion macros used by the touch event tracker RTL.
`ifndef TOUCH_EVENT_TRACKER_CORE_ASSERT_SVH
`define TOUCH_EVENT_TRACKER_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define TET_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("touch tracker invariant violated");

// Check that a trigger in one cycle is followed by a condition in the next.
`define TET_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("touch tracker sequence violated");

`endif

[hdl/tet_pkg.sv]
// Types, codes and reset constants of the touch event tracker.
`timescale 1ns / 1ps
package tet_pkg;

   localparam int CoordWidth = 12;
   localparam int TickWidth  = 16;

   // request kinds
   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_EDGE = 2'd1;
   localparam logic [1:0] KIND_POLL = 2'd2;

   // poll result codes
   localparam logic [1:0] CODE_OK         = 2'd0;
   localparam logic [1:0] CODE_NO_CONTACT = 2'd1;
   localparam logic [1:0] CODE_BUS_BUSY   = 2'd2;

   // touch status codes
   localparam logic [1:0] STATUS_NONE  = 2'd0;
   localparam logic [1:0] STATUS_CLICK = 2'd1;
   localparam logic [1:0] STATUS_HOLD  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_TICK_PERIOD    = 2'd0;
   localparam logic [1:0] CSR_HOLD_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_IN_IRQ  = 2'd2;

   localparam logic [TickWidth-1:0] TICK_PERIOD_RESET    = 16'd1;
   localparam logic [TickWidth-1:0] HOLD_THRESHOLD_RESET = 16'd500;

   typedef struct packed {
      logic [1:0]            kind;
      logic                  pen_down_before;
      logic                  pen_down_after;
      logic                  bus_busy;
      logic [CoordWidth-1:0] x_sample;
      logic [CoordWidth-1:0] y_sample;
   } req_type;

   typedef struct packed {
      logic [1:0]            poll_code;
      logic                  touched;
      logic [1:0]            touch_status;
      logic [CoordWidth-1:0] x_pos;
      logic [CoordWidth-1:0] y_pos;
      logic                  edge_irq_enabled;
      logic                  timer_running;
      logic [TickWidth-1:0]  last_touch_ticks;
   } rsp_type;

   typedef struct packed {
      logic [TickWidth-1:0] tick_period;
      logic [TickWidth-1:0] hold_threshold;
      logic                 sample_in_interrupt;
   } cfg_type;

   typedef struct packed {
      logic                  timer_on;
      logic [TickWidth-1:0]  timer_count;
      logic                  waiting_rearm;
      logic                  edge_enable;
      logic [TickWidth-1:0]  touch_ticks;
      logic [TickWidth-1:0]  prior_ticks;
      logic [1:0]            status;
      logic                  contact_flag;
      logic [CoordWidth-1:0] coord_x;
      logic [CoordWidth-1:0] coord_y;
   } state_type;

   localparam cfg_type CFG_RESET = '{
      tick_period:         TICK_PERIOD_RESET,
      hold_threshold:      HOLD_THRESHOLD_RESET,
      sample_in_interrupt: 1'b0
   };

   localparam state_type STATE_RESET = '{
      timer_on:      1'b0,
      timer_count:   '0,
      waiting_rearm: 1'b0,
      edge_enable:   1'b1,
      touch_ticks:   '0,
      prior_ticks:   '0,
      status:        STATUS_NONE,
      contact_flag:  1'b0,
      coord_x:       '0,
      coord_y:       '0
   };

endpackage

[hdl/tet_if.sv]
// Valid/ready channel interfaces for tracker requests and responses.
`timescale 1ns / 1ps
interface tet_req_if;
   logic             valid;
   logic             ready;
   tet_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tet_rsp_if;
   logic             valid;
   logic             ready;
   tet_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hdl/touch_event_tracker_core.sv]
// Touch event tracker: top level with state, registers and response buffer.
//
// Requests arrive on req_ch (valid/ready): a timer tick, a pen-down edge
// interrupt or a software poll, each carrying pen levels, a bus-busy flag
// and averaged X/Y samples. Every request yields exactly one response on
// rsp_ch with the poll code, touch status, coordinates, edge-interrupt and
// timer enables and the duration of the last completed touch.
// Throughput: one request per cycle while req_ch.ready is high. The whole
// update (including the 16x16 duration-times-period multiply for the hold
// check) is combinational from the state registers into the response
// buffer, which registers the response.
// Registers are written through csr_we/csr_index/csr_wdata: index 0 tick
// period, 1 hold threshold, 2 sampling mode; write them only while idle.
// Reset (synchronous, active high) restores the register defaults, clears
// the tracker state with the edge interrupt enabled, and empties the
// response buffer. When rsp_ch stalls, a second response is parked in a
// skid register; req_ch.ready drops only while both entries are full.
`timescale 1ns / 1ps
module touch_event_tracker_core (
   input  logic                          clock,
   input  logic                          reset,
   tet_req_if.sink                       req_ch,
   tet_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [tet_pkg::TickWidth-1:0] csr_wdata
);

   `include "touch_event_tracker_core_assert.svh"

   tet_pkg::cfg_type   cfg_ff;
   tet_pkg::cfg_type   cfg_in;
   tet_pkg::state_type state_ff;
   tet_pkg::state_type state_in;
   tet_pkg::state_type state_nxt;
   tet_pkg::rsp_type   rsp_data;
   logic [1:0]         poll_code;
   logic               req_fire;
   logic               buf_ready;

   assign req_ch.ready = buf_ready;
   assign req_fire     = req_ch.valid && buf_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            tet_pkg::CSR_TICK_PERIOD:    cfg_in.tick_period = csr_wdata;
            tet_pkg::CSR_HOLD_THRESHOLD: cfg_in.hold_threshold = csr_wdata;
            tet_pkg::CSR_SAMPLE_IN_IRQ:  cfg_in.sample_in_interrupt = csr_wdata[0];
            default: ;
         endcase
      end
   end

   tet_step u_step (
      .cur       (state_ff),
      .cfg       (cfg_ff),
      .req       (req_ch.data),
      .nxt       (state_nxt),
      .poll_code (poll_code)
   );

   // advance state only on an accepted request
   assign state_in = req_fire ? state_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= tet_pkg::CFG_RESET;
         state_ff <= tet_pkg::STATE_RESET;
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
      end
   end

   always_comb begin
      rsp_data.poll_code        = poll_code;
      rsp_data.touched          = state_nxt.contact_flag;
      rsp_data.touch_status     = state_nxt.status;
      rsp_data.x_pos            = state_nxt.coord_x;
      rsp_data.y_pos            = state_nxt.coord_y;
      rsp_data.edge_irq_enabled = state_nxt.edge_enable;
      rsp_data.timer_running    = state_nxt.timer_on;
      rsp_data.last_touch_ticks = state_nxt.prior_ticks;
   end

   tet_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (buf_ready),
      .in_data   (rsp_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_ch.data)
   );

   `TET_ASSERT_ALWAYS(a_edge_vs_timer, state_ff.edge_enable != state_ff.timer_on)
   `TET_ASSERT_ALWAYS(a_contact_vs_status,
      state_ff.contact_flag == (state_ff.status != tet_pkg::STATUS_NONE))
   `TET_ASSERT_ALWAYS(a_backpressure_full, req_ch.ready || rsp_ch.valid)
   `TET_ASSERT_NEXT(a_edge_starts_touch,
      req_fire && req_ch.data.kind == tet_pkg::KIND_EDGE && state_ff.edge_enable &&
         req_ch.data.pen_down_before,
      state_ff.timer_on && state_ff.touch_ticks == '0)

endmodule

[hdl/tet_step.sv]
// Next-state and poll-code logic for one tracker request.
`timescale 1ns / 1ps
module tet_step (
   input  tet_pkg::state_type cur,
   input  tet_pkg::cfg_type   cfg,
   input  tet_pkg::req_type   req,
   output tet_pkg::state_type nxt,
   output logic [1:0]         poll_code
);

   logic [tet_pkg::TickWidth-1:0]   cnt_dec;
   logic [2*tet_pkg::TickWidth-1:0] hold_product;
   logic                            hold_hit;
   logic [1:0]                      samp_code;
   logic                            is_tick;
   logic                            is_edge;
   logic                            is_poll;
   logic                            expire;
   logic                            rearm;
   logic                            sample_en;
   logic                            take_sample;
   logic                            drop_touch;
   logic                            count_tick;

   always_comb begin
      is_tick = 1'b0;
      is_edge = 1'b0;
      is_poll = 1'b0;
      case (req.kind)
         tet_pkg::KIND_TICK: is_tick = 1'b1;
         tet_pkg::KIND_EDGE: is_edge = 1'b1;
         tet_pkg::KIND_POLL: is_poll = 1'b1;
         default: ;
      endcase
   end

   assign hold_product = (2*tet_pkg::TickWidth)'(cur.touch_ticks) *
                         (2*tet_pkg::TickWidth)'(cfg.tick_period);
   assign hold_hit = hold_product >= (2*tet_pkg::TickWidth)'(cfg.hold_threshold);

   always_comb begin
      if (!req.pen_down_before) begin
         samp_code = tet_pkg::CODE_NO_CONTACT;
      end else if (req.bus_busy) begin
         samp_code = tet_pkg::CODE_BUS_BUSY;
      end else if (!req.pen_down_after) begin
         samp_code = tet_pkg::CODE_NO_CONTACT;
      end else begin
         samp_code = tet_pkg::CODE_OK;
      end
   end

   assign cnt_dec     = cur.timer_count - 16'd1;
   assign expire      = is_tick && cur.timer_on && (cnt_dec == '0);
   assign rearm       = expire && cur.waiting_rearm;
   assign sample_en   = (expire && !cur.waiting_rearm && cfg.sample_in_interrupt) ||
                        (is_poll && !cfg.sample_in_interrupt);
   assign take_sample = sample_en && (samp_code == tet_pkg::CODE_OK);
   assign drop_touch  = sample_en && (samp_code == tet_pkg::CODE_NO_CONTACT);
   assign count_tick  = expire && !cur.waiting_rearm && !drop_touch;

   assign poll_code = (is_poll && !cfg.sample_in_interrupt) ? samp_code : tet_pkg::CODE_OK;

   always_comb begin
      nxt = cur;
      if (is_tick && cur.timer_on) begin
         nxt.timer_count = expire ? cfg.tick_period : cnt_dec;
      end
      if (rearm) begin
         nxt.waiting_rearm = 1'b0;
         nxt.timer_on      = 1'b0;
         nxt.edge_enable   = 1'b1;
      end
      if (take_sample) begin
         nxt.contact_flag = 1'b1;
         nxt.coord_x      = req.x_sample;
         nxt.coord_y      = req.y_sample;
         if (cur.status == tet_pkg::STATUS_NONE) begin
            nxt.status = tet_pkg::STATUS_CLICK;
         end else if (cur.status == tet_pkg::STATUS_CLICK && hold_hit) begin
            nxt.status = tet_pkg::STATUS_HOLD;
         end
      end
      // pen lifted: record duration and arm the edge re-enable
      if (drop_touch) begin
         nxt.contact_flag  = 1'b0;
         nxt.status        = tet_pkg::STATUS_NONE;
         nxt.prior_ticks   = cur.touch_ticks;
         nxt.waiting_rearm = 1'b1;
         nxt.timer_count   = cfg.tick_period;
      end
      if (count_tick && (cur.touch_ticks != '1)) begin
         nxt.touch_ticks = cur.touch_ticks + 16'd1;
      end
      if (is_edge && cur.edge_enable && req.pen_down_before) begin
         nxt.timer_on    = 1'b1;
         nxt.timer_count = cfg.tick_period;
         nxt.touch_ticks = '0;
         nxt.edge_enable = 1'b0;
      end
   end

endmodule

[hdl/tet_rsp_buf.sv]
// Two-entry response buffer: output register plus skid register.
`timescale 1ns / 1ps
module tet_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  tet_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output tet_pkg::rsp_type out_data
);

   logic             out_valid_ff;
   logic             out_valid_in;
   logic             skid_valid_ff;
   logic             skid_valid_in;
   tet_pkg::rsp_type out_data_ff;
   tet_pkg::rsp_type out_data_in;
   tet_pkg::rsp_type skid_data_ff;
   tet_pkg::rsp_type skid_data_in;
   logic             push;
   logic             pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign push      = in_valid && !skid_valid_ff;
   assign pop       = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_data_in = in_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         // no pop: park the new response in the skid entry if the output is stalled, else load the output entry
         if (out_valid_ff) begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end else begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

[dv/tb.sv]
// Self-checking testbench for the touch event tracker core.
`timescale 1ns / 1ps
module tb;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 300;
   localparam logic [15:0] PHASE_PERIOD [PHASES] = '{16'd1, 16'd2, 16'd1, 16'd3, 16'd5, 16'd1};
   localparam logic [15:0] PHASE_THRESH [PHASES] = '{16'd4, 16'd10, 16'd0, 16'd20, 16'd3, 16'd40};
   localparam logic PHASE_IRQ [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   tet_req_if req_if ();
   tet_rsp_if rsp_if ();

   touch_event_tracker_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // tracker image: registers and state
   logic [15:0] cfg_period;
   logic [15:0] cfg_threshold;
   logic        cfg_irq_mode;
   logic        trk_timer_on;
   logic [15:0] trk_count;
   logic        trk_rearm_wait;
   logic        trk_edge_en;
   logic [15:0] trk_ticks;
   logic [15:0] trk_last_ticks;
   logic [1:0]  trk_status;
   logic        trk_contact;
   logic [11:0] trk_x;
   logic [11:0] trk_y;

   tet_pkg::rsp_type tracker_reports [$];
   int      fault_count = 0;
   int      cycle_count = 0;
   bit      no_gaps = 1'b0;
   bit      hold_off_request = 1'b0;
   bit      pen_pressed = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic void reset_tracker_model();
      cfg_period     = tet_pkg::TICK_PERIOD_RESET;
      cfg_threshold  = tet_pkg::HOLD_THRESHOLD_RESET;
      cfg_irq_mode   = 1'b0;
      trk_timer_on   = 1'b0;
      trk_count      = '0;
      trk_rearm_wait = 1'b0;
      trk_edge_en    = 1'b1;
      trk_ticks      = '0;
      trk_last_ticks = '0;
      trk_status     = tet_pkg::STATUS_NONE;
      trk_contact    = 1'b0;
      trk_x          = '0;
      trk_y          = '0;
   endfunction

   function automatic logic [1:0] take_sample(input tet_pkg::req_type r);
      if (!r.pen_down_before) return tet_pkg::CODE_NO_CONTACT;
      if (r.bus_busy) return tet_pkg::CODE_BUS_BUSY;
      if (!r.pen_down_after) return tet_pkg::CODE_NO_CONTACT;
      trk_contact = 1'b1;
      if (trk_status == tet_pkg::STATUS_NONE) begin
         trk_status = tet_pkg::STATUS_CLICK;
      end else if (trk_status == tet_pkg::STATUS_CLICK &&
                   {16'd0, trk_ticks} * {16'd0, cfg_period} >= {16'd0, cfg_threshold}) begin
         trk_status = tet_pkg::STATUS_HOLD;
      end
      trk_x = r.x_sample;
      trk_y = r.y_sample;
      return tet_pkg::CODE_OK;
   endfunction

   function automatic void end_touch();
      trk_contact    = 1'b0;
      trk_status     = tet_pkg::STATUS_NONE;
      trk_last_ticks = trk_ticks;
      trk_rearm_wait = 1'b1;
      trk_count      = cfg_period;
   endfunction

   function automatic tet_pkg::rsp_type track_event(input tet_pkg::req_type r);
      tet_pkg::rsp_type p;
      logic [1:0] code;
      logic [1:0] tick_code;
      code = tet_pkg::CODE_OK;
      tick_code = tet_pkg::CODE_OK;
      case (r.kind)
         tet_pkg::KIND_TICK: begin
            if (trk_timer_on) begin
               trk_count = trk_count - 16'd1;
               if (trk_count == 16'd0) begin
                  trk_count = cfg_period;
                  if (trk_rearm_wait) begin
                     trk_rearm_wait = 1'b0;
                     trk_timer_on   = 1'b0;
                     trk_edge_en    = 1'b1;
                  end else begin
                     if (cfg_irq_mode) tick_code = take_sample(r);
                     if (tick_code == tet_pkg::CODE_NO_CONTACT) begin
                        end_touch();
                     end else if (trk_ticks != 16'hFFFF) begin
                        trk_ticks = trk_ticks + 16'd1;
                     end
                  end
               end
            end
         end
         tet_pkg::KIND_EDGE: begin
            if (trk_edge_en && r.pen_down_before) begin
               trk_timer_on = 1'b1;
               trk_count    = cfg_period;
               trk_ticks    = '0;
               trk_edge_en  = 1'b0;
            end
         end
         tet_pkg::KIND_POLL: begin
            if (!cfg_irq_mode) begin
               code = take_sample(r);
               if (code == tet_pkg::CODE_NO_CONTACT) end_touch();
            end
         end
         default: begin
         end
      endcase
      p.poll_code        = code;
      p.touched          = trk_contact;
      p.touch_status     = trk_status;
      p.x_pos            = trk_x;
      p.y_pos            = trk_y;
      p.edge_irq_enabled = trk_edge_en;
      p.timer_running    = trk_timer_on;
      p.last_touch_ticks = trk_last_ticks;
      return p;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (tracker_reports.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_if.data);
            fault_count++;
         end else begin
            tet_pkg::rsp_type want;
            tet_pkg::rsp_type got;
            want = tracker_reports.pop_front();
            got  = rsp_if.data;
            check_field("poll_code", 16'(want.poll_code), 16'(got.poll_code));
            check_field("touched", 16'(want.touched), 16'(got.touched));
            check_field("touch_status", 16'(want.touch_status), 16'(got.touch_status));
            check_field("x_pos", 16'(want.x_pos), 16'(got.x_pos));
            check_field("y_pos", 16'(want.y_pos), 16'(got.y_pos));
            check_field("edge_irq_enabled", 16'(want.edge_irq_enabled),
                        16'(got.edge_irq_enabled));
            check_field("timer_running", 16'(want.timer_running), 16'(got.timer_running));
            check_field("last_touch_ticks", want.last_touch_ticks, got.last_touch_ticks);
         end
      end
   end

   // response side: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= no_gaps || ($urandom_range(99) >= 22);
         end
      end
   end

   function automatic tet_pkg::req_type touch_request(input logic [1:0] kind,
                                                      input logic down_start,
                                                      input logic down_end,
                                                      input logic busy,
                                                      input logic [11:0] x,
                                                      input logic [11:0] y);
      tet_pkg::req_type r;
      r.kind            = kind;
      r.pen_down_before = down_start;
      r.pen_down_after  = down_end;
      r.bus_busy        = busy;
      r.x_sample        = x;
      r.y_sample        = y;
      return r;
   endfunction

   function automatic tet_pkg::req_type random_request();
      tet_pkg::req_type r;
      int      pick;
      if ($urandom_range(39) == 0) pen_pressed = !pen_pressed;
      pick = $urandom_range(99);
      if (pick < 55) r.kind = tet_pkg::KIND_TICK;
      else if (pick < 70) r.kind = tet_pkg::KIND_EDGE;
      else if (pick < 95) r.kind = tet_pkg::KIND_POLL;
      else r.kind = KIND_UNUSED;
      r.pen_down_before = ($urandom_range(9) == 0) ? !pen_pressed : pen_pressed;
      r.pen_down_after  = ($urandom_range(9) == 0) ? !pen_pressed : pen_pressed;
      r.bus_busy        = ($urandom_range(9) == 0);
      r.x_sample        = 12'($urandom_range(4095));
      r.y_sample        = 12'($urandom_range(4095));
      // some pure noise
      if ($urandom_range(9) == 0) begin
         r = tet_pkg::req_type'($bits(tet_pkg::req_type)'($urandom));
      end
      return r;
   endfunction

   task automatic send_request(input tet_pkg::req_type r);
      if (!no_gaps && $urandom_range(99) < 22) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker_reports.push_back(track_event(r));
   endtask

   task automatic wait_for_reports();
      req_if.valid <= 1'b0;
      while (tracker_reports.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         tet_pkg::CSR_TICK_PERIOD: cfg_period = value;
         tet_pkg::CSR_HOLD_THRESHOLD: cfg_threshold = value;
         tet_pkg::CSR_SAMPLE_IN_IRQ: cfg_irq_mode = value[0];
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] period, input logic [15:0] threshold,
                                 input logic irq_mode);
      wait_for_reports();
      write_register(tet_pkg::CSR_TICK_PERIOD, period);
      write_register(tet_pkg::CSR_HOLD_THRESHOLD, threshold);
      write_register(tet_pkg::CSR_SAMPLE_IN_IRQ, {15'd0, irq_mode});
   endtask

   // lift the pen and tick until the edge interrupt is armed again
   task automatic end_and_rearm();
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0));
      while (trk_timer_on)
         send_request(touch_request(tet_pkg::KIND_TICK, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0));
   endtask

   task automatic test_directed_events();
      // reset state first: ignored tick, unused kind, edge with pen up
      send_request(touch_request(tet_pkg::KIND_TICK, 1'b1, 1'b1, 1'b1, 12'd4095, 12'd4095));
      send_request(touch_request(KIND_UNUSED, 1'b1, 1'b1, 1'b1, 12'd4095, 12'd4095));
      send_request(touch_request(tet_pkg::KIND_EDGE, 1'b0, 1'b1, 1'b0, 12'd0, 12'd0));
      apply_settings(16'd1, 16'd2, 1'b0);
      send_request(touch_request(tet_pkg::KIND_EDGE, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0));
      send_request(touch_request(tet_pkg::KIND_EDGE, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0));
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b1, 1'b1, 1'b1, 12'd100, 12'd200));
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b1, 1'b1, 1'b0, 12'd4095, 12'd0));
      send_request(touch_request(tet_pkg::KIND_TICK, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0));
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b1, 1'b1, 1'b0, 12'd0, 12'd4095));
      send_request(touch_request(tet_pkg::KIND_TICK, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0));
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b1, 1'b1, 1'b0, 12'd2048, 12'd1024));
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b1, 1'b0, 1'b0, 12'd7, 12'd9));
      send_request(touch_request(tet_pkg::KIND_TICK, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0));
      // interrupt mode: sampling moves to timer expiry
      apply_settings(16'd1, 16'd2, 1'b1);
      send_request(touch_request(tet_pkg::KIND_EDGE, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0));
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b1, 1'b1, 1'b0, 12'd55, 12'd66));
      send_request(touch_request(tet_pkg::KIND_TICK, 1'b1, 1'b1, 1'b1, 12'd1, 12'd2));
      send_request(touch_request(tet_pkg::KIND_TICK, 1'b1, 1'b1, 1'b0, 12'd4095, 12'd4095));
      send_request(touch_request(tet_pkg::KIND_TICK, 1'b1, 1'b1, 1'b0, 12'd300, 12'd400));
      send_request(touch_request(tet_pkg::KIND_TICK, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0));
      send_request(touch_request(tet_pkg::KIND_TICK, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0));
      send_request(touch_request(KIND_UNUSED, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0));
   endtask

   task automatic test_duration_saturation();
      apply_settings(16'd1, 16'hFFFF, 1'b0);
      no_gaps = 1'b1;
      send_request(touch_request(tet_pkg::KIND_EDGE, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0));
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b1, 1'b1, 1'b0, 12'd10, 12'd20));
      while (trk_ticks != 16'hFFFE)
         send_request(touch_request(tet_pkg::KIND_TICK, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0));
      // one short of the threshold: still a click
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b1, 1'b1, 1'b0, 12'd30, 12'd40));
      send_request(touch_request(tet_pkg::KIND_TICK, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0));
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b1, 1'b1, 1'b0, 12'd50, 12'd60));
      repeat (3)
         send_request(touch_request(tet_pkg::KIND_TICK, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0));
      no_gaps = 1'b0;
      end_and_rearm();
   endtask

   task automatic test_random_traffic();
      for (int ph = 0; ph < PHASES; ph++) begin
         apply_settings(PHASE_PERIOD[ph], PHASE_THRESH[ph], PHASE_IRQ[ph]);
         repeat (PHASE_ITEMS) send_request(random_request());
      end
   endtask

   task automatic test_backpressure();
      apply_settings(16'd2, 16'd6, 1'b1);
      hold_off_request = 1'b1;
      repeat (30) send_request(random_request());
      // pause until everything has drained
      wait_for_reports();
      repeat (10) send_request(random_request());
   endtask

   task automatic test_register_extremes();
      end_and_rearm();
      apply_settings(16'hFFFF, 16'hFFFF, 1'b1);
      send_request(touch_request(tet_pkg::KIND_EDGE, 1'b1, 1'b1, 1'b0, 12'd4095, 12'd4095));
      repeat (4)
         send_request(touch_request(tet_pkg::KIND_TICK, 1'b1, 1'b1, 1'b0, 12'd1, 12'd1));
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b1, 1'b1, 1'b0, 12'd4095, 12'd4095));
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0));
      apply_settings(16'd1, 16'hFFFF, 1'b0);
      end_and_rearm();
      // zero period: the reload of 0 wraps on the next tick
      apply_settings(16'd0, 16'd0, 1'b0);
      send_request(touch_request(tet_pkg::KIND_EDGE, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0));
      send_request(touch_request(tet_pkg::KIND_TICK, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0));
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b1, 1'b1, 1'b0, 12'd111, 12'd222));
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b1, 1'b1, 1'b0, 12'd333, 12'd444));
      send_request(touch_request(tet_pkg::KIND_TICK, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0));
      send_request(touch_request(tet_pkg::KIND_POLL, 1'b0, 1'b1, 1'b0, 12'd0, 12'd0));
      send_request(touch_request(tet_pkg::KIND_TICK, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0));
      apply_settings(16'd1, tet_pkg::HOLD_THRESHOLD_RESET, 1'b0);
      end_and_rearm();
   endtask

   initial begin
      reset_tracker_model();
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_we       <= 1'b0;
      csr_index    <= tet_pkg::CSR_TICK_PERIOD;
      csr_wdata    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_events();
      test_duration_saturation();
      test_random_traffic();
      test_backpressure();
      test_register_extremes();
      wait_for_reports();
      repeat (4) @(posedge clock);
      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

[sim.f]
+incdir+hdl
hdl/tet_pkg.sv
hdl/tet_if.sv
hdl/tet_step.sv
hdl/tet_rsp_buf.sv
hdl/touch_event_tracker_core.sv
dv/tb.sv
